/* sv/hslt_pkg.sv */
`default_nettype none
package hslt_pkg;

	localparam int CAPACITY   = 16;
	localparam int CALL_CHARS = 10;
	localparam int IDX_W      = $clog2(CAPACITY);
	localparam int CNT_W      = $clog2(CAPACITY + 1);
	localparam int CUR_W      = CNT_W + 1;
	localparam int CALL_W     = 80;

	localparam logic [2:0] REQ_TOUCH   = 3'd0;
	localparam logic [2:0] REQ_RM_CALL = 3'd1;
	localparam logic [2:0] REQ_RM_PORT = 3'd2;
	localparam logic [2:0] REQ_CLEAR   = 3'd3;
	localparam logic [2:0] REQ_FIRST   = 3'd4;
	localparam logic [2:0] REQ_NEXT    = 3'd5;

	localparam logic [CUR_W-1:0] CUR_END = '1;

	// One stored station, as held in the slot memory.
	typedef struct packed {
		logic [63:0]        call_head;
		logic [15:0]        call_tail;
		logic [3:0]         port;
		logic [31:0]        heard_time;
		logic signed [16:0] distance;
		logic [8:0]         bearing;
	} rec_t;

	localparam int REC_W = $bits(rec_t);

	// Keeps the first CALL_CHARS bytes up to the first zero byte; the rest reads as zero.
	function automatic logic [CALL_W-1:0] norm_call(input logic [CALL_W-1:0] c);
		logic [CALL_W-1:0] r;
		logic ended;
		r = '0;
		ended = 1'b0;
		for (int i = 0; i < 10; i++) begin
			if (i >= CALL_CHARS || c[CALL_W-1-8*i -: 8] == 8'd0)
				ended = 1'b1;
			r[CALL_W-1-8*i -: 8] = ended ? 8'd0 : c[CALL_W-1-8*i -: 8];
		end
		return r;
	endfunction

	function automatic logic [CALL_W-1:0] upcase_call(input logic [CALL_W-1:0] c);
		logic [CALL_W-1:0] r;
		logic [7:0] b;
		r = '0;
		b = '0;
		for (int i = 0; i < 10; i++) begin
			b = c[8*i +: 8];
			r[8*i +: 8] = (b >= 8'h61 && b <= 8'h7A) ? b - 8'd32 : b;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

/* sv/hslt_ram.sv */
`default_nettype none
module hslt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

/* sv/heard_station_lru_table.sv */
// Heard-station table with move-to-front recency order.
// Each input transaction on s_axis carries one request in s_axis_tuser (touch,
// remove by call, remove by port, clear, first, next) and the station fields in
// s_axis_tdata. Every request gives exactly one result transaction on m_axis;
// m_axis_tuser is the found flag and m_axis_tdata holds the returned entry.
// The station records live in one synchronous slot memory. Requests are
// handled one at a time: a scan visits entries newest first, with a memory
// read state and then a compare state for each visited entry. Clear and an
// unused code finish without a scan.
// The result sits in an output register, so a new request is taken while the
// previous result still waits; if the receiver stalls the block finishes the
// next request and then holds until the output register is free.
// Reset empties the table, ends any first/next iteration and sets max_entries
// to 16. The slot memory is not cleared; only occupied slots are ever read. The user
// writes max_entries via cfg_we/cfg_wdata only while idle; the block does not enforce it.
`default_nettype none
module heard_station_lru_table (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_we,
	input  wire logic [4:0]   cfg_wdata,      // max_entries
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// call_head, call_tail, port, heard_time, bearing_known, new_bearing,
	// distance_sane, new_distance
	input  wire logic [143:0] s_axis_tdata,
	input  wire logic [2:0]   s_axis_tuser,   // req_type
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// out_call_head, out_call_tail, out_port, out_time, out_distance,
	// out_bearing, two zero bits
	output logic [143:0]      m_axis_tdata,
	output logic              m_axis_tuser    // entry_found
);
	import hslt_pkg::*;

	typedef enum logic [2:0] {ST_IDLE, ST_RD, ST_CMP, ST_WR, ST_DONE} state_t;

	state_t state_q;

	// Latched request.
	logic [2:0]        req_q;
	logic [CALL_W-1:0] call_q;
	logic [CALL_W-1:0] ucall_q;
	logic signed [4:0] port_q;
	logic [31:0]       time_q;
	logic              bk_q, ds_q;
	logic [8:0]        nb_q;
	logic [15:0]       nd_q;

	// Table control state.
	logic [4:0]        max_q;
	logic [IDX_W-1:0]  order_q [CAPACITY];
	logic [CAPACITY-1:0] used_q;
	logic [CNT_W-1:0]  count_q;
	logic [CUR_W-1:0]  cursor_q;
	logic [CNT_W-1:0]  rank_q;

	// Touch bookkeeping.
	logic              took_q, clr_q;
	logic [IDX_W-1:0]  slot_q;
	rec_t              old_q;

	rec_t              res_q;
	logic              res_found_q;
	rec_t              out_q;
	logic              out_found_q;
	logic              out_valid_q;

	// Slot memory.
	rec_t              rdata;
	rec_t              wrec;
	logic              ram_we;
	logic [IDX_W-1:0]  ram_waddr;

	// Input fields.
	logic [CALL_W-1:0] in_call;
	logic [CALL_W-1:0] in_norm;
	assign in_call = {s_axis_tdata[63:0], s_axis_tdata[79:64]};
	assign in_norm = norm_call(in_call);

	logic in_accept;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_accept = s_axis_tvalid && s_axis_tready;

	// The finished result moves into the output register when that register is free.
	logic out_load;
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || m_axis_tready);

	// Effective limit: zero acts as one, anything above the capacity as the capacity.
	logic [CNT_W-1:0] lim;
	always_comb begin
		if (max_q == 5'd0)
			lim = CNT_W'(1);
		else if (int'(max_q) > CAPACITY)
			lim = CNT_W'(CAPACITY);
		else
			lim = CNT_W'(max_q);
	end

	// Lowest free slot, used when a touch takes no existing entry.
	logic [IDX_W-1:0] free_slot;
	always_comb begin
		free_slot = '0;
		for (int i = CAPACITY - 1; i >= 0; i--)
			if (!used_q[i])
				free_slot = IDX_W'(i);
	end

	// Compare of the entry just read against the request.
	logic call_eq, port_eq, port_ok, scan_end;
	logic [IDX_W-1:0] cur_slot;
	assign cur_slot = order_q[rank_q[IDX_W-1:0]];
	assign call_eq  = (upcase_call({rdata.call_head, rdata.call_tail}) == ucall_q);
	assign port_ok  = !port_q[4];
	assign port_eq  = port_ok && (rdata.port == port_q[3:0]);
	assign scan_end = (rank_q >= count_q);

	// Record written by a touch.
	always_comb begin
		wrec.call_head  = call_q[79:16];
		wrec.call_tail  = call_q[15:0];
		wrec.port       = port_q[3:0];
		wrec.heard_time = time_q;
		if (bk_q)
			wrec.bearing = nb_q;
		else
			wrec.bearing = clr_q ? 9'd0 : old_q.bearing;
		if (bk_q && ds_q)
			wrec.distance = {1'b0, nd_q};
		else
			wrec.distance = clr_q ? -17'sd1 : old_q.distance;
	end

	assign ram_we    = (state_q == ST_WR);
	assign ram_waddr = took_q ? slot_q : free_slot;

	hslt_ram #(
		.WIDTH(REC_W),
		.DEPTH(CAPACITY)
	) u_slots (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(wrec),
		.raddr(cur_slot),
		.rdata(rdata)
	);

	logic [CNT_W-1:0] ins_rank;
	assign ins_rank = took_q ? rank_q : count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			max_q       <= 5'd16;
			used_q      <= '0;
			count_q     <= '0;
			cursor_q    <= CUR_END;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we)
				max_q <= cfg_wdata;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_valid_q && m_axis_tready)
				out_valid_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						req_q       <= s_axis_tuser;
						call_q      <= in_norm;
						ucall_q     <= upcase_call(in_norm);
						port_q      <= s_axis_tdata[84:80];
						time_q      <= s_axis_tdata[116:85];
						bk_q        <= s_axis_tdata[117];
						nb_q        <= s_axis_tdata[126:118];
						ds_q        <= s_axis_tdata[127];
						nd_q        <= s_axis_tdata[143:128];
						res_q       <= '0;
						res_found_q <= 1'b0;
						rank_q      <= (s_axis_tuser == REQ_NEXT) ?
							cursor_q[CNT_W-1:0] : '0;
						took_q      <= 1'b0;
						clr_q       <= 1'b1;
						if (s_axis_tuser <= REQ_CLEAR)
							cursor_q <= CUR_END;
						case (s_axis_tuser)
							REQ_TOUCH: begin
								state_q <= s_axis_tdata[84] ? ST_DONE : ST_RD;
							end
							REQ_RM_CALL, REQ_RM_PORT, REQ_FIRST: begin
								state_q <= ST_RD;
							end
							REQ_CLEAR: begin
								used_q  <= '0;
								count_q <= '0;
								state_q <= ST_DONE;
							end
							REQ_NEXT: begin
								if (cursor_q >= CUR_W'(count_q)) begin
									cursor_q <= CUR_END;
									state_q  <= ST_DONE;
								end else begin
									state_q <= ST_RD;
								end
							end
							default: begin
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_RD: begin
					// The read of the slot at this rank is issued here.
					if (scan_end) begin
						if (req_q == REQ_TOUCH)
							state_q <= ST_WR;
						else begin
							if (req_q == REQ_FIRST || req_q == REQ_NEXT)
								cursor_q <= CUR_END;
							state_q <= ST_DONE;
						end
					end else begin
						state_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					case (req_q)
						REQ_TOUCH: begin
							if ((call_eq && port_eq) || (rank_q + CNT_W'(1) == lim)) begin
								took_q  <= 1'b1;
								clr_q   <= (rank_q + CNT_W'(1) == lim);
								slot_q  <= cur_slot;
								old_q   <= rdata;
								state_q <= ST_WR;
							end else begin
								rank_q  <= rank_q + CNT_W'(1);
								state_q <= ST_RD;
							end
						end
						REQ_RM_CALL, REQ_RM_PORT: begin
							state_q <= ST_RD;
							if ((req_q == REQ_RM_CALL) ? call_eq : port_eq) begin
								// Drop this rank; the next entry moves up into it.
								used_q[cur_slot] <= 1'b0;
								for (int k = 0; k < CAPACITY - 1; k++)
									if (CNT_W'(k) >= rank_q && CNT_W'(k + 1) < count_q)
										order_q[k] <= order_q[k + 1];
								count_q <= count_q - CNT_W'(1);
							end else begin
								rank_q <= rank_q + CNT_W'(1);
							end
						end
						default: begin
							if (port_q == -5'sd1 || port_eq) begin
								cursor_q    <= CUR_W'(rank_q) + CUR_W'(1);
								res_q       <= rdata;
								res_found_q <= 1'b1;
								state_q     <= ST_DONE;
							end else begin
								rank_q  <= rank_q + CNT_W'(1);
								state_q <= ST_RD;
							end
						end
					endcase
				end
				ST_WR: begin
					// Move the entry to the front: ranks up to its old place shift down one.
					order_q[0] <= ram_waddr;
					for (int k = 1; k < CAPACITY; k++)
						if (CNT_W'(k) <= ins_rank)
							order_q[k] <= order_q[k - 1];
					used_q[ram_waddr] <= 1'b1;
					if (!took_q)
						count_q <= count_q + CNT_W'(1);
					res_q       <= wrec;
					res_found_q <= 1'b1;
					state_q     <= ST_DONE;
				end
				ST_DONE: begin
					if (out_load) begin
						out_q       <= res_q;
						out_found_q <= res_found_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_found_q;
	assign m_axis_tdata  = {2'b00, out_q.bearing, out_q.distance, out_q.heard_time,
		out_q.port, out_q.call_tail, out_q.call_head};

	// The table never holds more stations than there are slots.
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		int'(count_q) <= CAPACITY)
		else $error("entry count above capacity");

	// An iteration cursor is either ended or inside the table.
	a_cursor: assert property (@(posedge clk) disable iff (!arst_n)
		cursor_q == CUR_END || cursor_q <= CUR_W'(count_q))
		else $error("cursor beyond table");

	// A touch write always leaves at least one station in the table.
	a_wr_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WR |=> count_q != '0)
		else $error("table empty after touch");

	// A finished result is never dropped while the output still waits.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !m_axis_tready |=> out_valid_q && $stable(out_q))
		else $error("pending result lost");

endmodule
`default_nettype wire

/* sim/tb_heard_station_lru_table.sv */
`timescale 1ns / 100ps
`default_nettype none
// Testbench for the heard-station table.
// A local copy of the table (slots, recency ranks, iteration cursor and
// max_entries) predicts the single result of every request. A checker process
// compares each result transaction with the oldest prediction.
module tb_heard_station_lru_table;
	import hslt_pkg::*;

	// Request codes the block does not define; they must leave the table alone.
	localparam logic [2:0] REQ_SPARE_6 = 3'd6;
	localparam logic [2:0] REQ_SPARE_7 = 3'd7;
	localparam int         SCAN_DONE   = 1000;
	localparam int         WATCHDOG    = 20000;
	localparam int         SETTLE      = 50;

	logic         clk;
	logic         arst_n;
	logic         cfg_we;
	logic [4:0]   cfg_wdata;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [143:0] s_axis_tdata;
	logic [2:0]   s_axis_tuser;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [143:0] m_axis_tdata;
	logic         m_axis_tuser;

	heard_station_lru_table uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// One expected answer from the table.
	typedef struct {
		bit        found;
		bit [63:0] head;
		bit [15:0] tail;
		bit [3:0]  port;
		bit [31:0] heard;
		bit [16:0] distance;
		bit [8:0]  brg;
	} station_res_t;

	station_res_t answer_q[$];
	int           fail_count = 0;

	// Local copy of the table. Calls are held as 80 bits, first byte on top.
	bit [79:0] st_call[CAPACITY];
	bit [3:0]  st_port[CAPACITY];
	bit [31:0] st_heard[CAPACITY];
	bit [16:0] st_dist[CAPACITY];
	bit [8:0]  st_brg[CAPACITY];
	bit        st_used[CAPACITY];
	int        rank_slot[CAPACITY];
	int        heard_count = 0;
	int        scan_pos = SCAN_DONE;
	int        max_setting = 16;

	// Only bytes up to the first zero count; everything after reads as zero.
	function automatic bit [79:0] clean_call(bit [79:0] c);
		bit [79:0] r;
		bit ended;
		r = '0;
		ended = 1'b0;
		for (int i = 0; i < 10; i++) begin
			if (i >= CALL_CHARS || c[79-8*i -: 8] == 8'd0)
				ended = 1'b1;
			if (!ended)
				r[79-8*i -: 8] = c[79-8*i -: 8];
		end
		return r;
	endfunction

	function automatic bit [79:0] fold_case(bit [79:0] c);
		bit [7:0] b;
		for (int i = 0; i < 10; i++) begin
			b = c[8*i +: 8];
			if (b >= "a" && b <= "z")
				c[8*i +: 8] = b - 8'd32;
		end
		return c;
	endfunction

	function automatic void drop_rank(int r);
		st_used[rank_slot[r]] = 1'b0;
		for (int k = r; k + 1 < heard_count; k++)
			rank_slot[k] = rank_slot[k+1];
		heard_count--;
	endfunction

	function automatic station_res_t report_slot(int s);
		station_res_t a;
		a.found    = 1'b1;
		a.head     = st_call[s][79:16];
		a.tail     = st_call[s][15:0];
		a.port     = st_port[s];
		a.heard    = st_heard[s];
		a.distance = st_dist[s];
		a.brg      = st_brg[s];
		return a;
	endfunction

	// Applies one accepted request to the local table and returns its answer.
	function automatic station_res_t apply_request(logic [2:0] req, bit [79:0] call_in,
			logic signed [4:0] port, bit [31:0] heard, bit bk, bit [8:0] brg, bit ds,
			bit [15:0] new_dist);
		station_res_t a;
		bit [79:0] key;
		int pi, lim, r, s, slot;
		bit took, hit;
		a = '{default: '0};
		key = clean_call(call_in);
		pi = port;
		lim = (max_setting == 0) ? 1 : (max_setting > CAPACITY ? CAPACITY : max_setting);
		took = 1'b0;
		slot = 0;
		if (req <= REQ_CLEAR)
			scan_pos = SCAN_DONE;
		case (req)
			REQ_TOUCH: begin
				if (pi >= 0) begin
					// The entry at rank max_entries is recycled even when it matches,
					// and in that case its position data is forgotten.
					for (r = 0; r < heard_count && !took; r++) begin
						s = rank_slot[r];
						hit = fold_case(key) == fold_case(st_call[s]) && st_port[s] == pi[3:0];
						if (hit || r + 1 == lim) begin
							slot = s;
							for (int k = r; k + 1 < heard_count; k++)
								rank_slot[k] = rank_slot[k+1];
							heard_count--;
							if (r + 1 == lim) begin
								st_dist[slot] = '1;
								st_brg[slot] = '0;
							end
							took = 1'b1;
						end
					end
					if (!took) begin
						for (slot = 0; slot < CAPACITY; slot++)
							if (!st_used[slot])
								break;
						st_dist[slot] = '1;
						st_brg[slot] = '0;
					end
					st_used[slot] = 1'b1;
					st_call[slot] = key;
					st_port[slot] = pi[3:0];
					st_heard[slot] = heard;
					if (bk) begin
						st_brg[slot] = brg;
						if (ds)
							st_dist[slot] = {1'b0, new_dist};
					end
					for (int k = heard_count; k > 0; k--)
						rank_slot[k] = rank_slot[k-1];
					rank_slot[0] = slot;
					heard_count++;
					a = report_slot(slot);
				end
			end
			REQ_RM_CALL: begin
				r = 0;
				while (r < heard_count) begin
					if (fold_case(key) == fold_case(st_call[rank_slot[r]]))
						drop_rank(r);
					else
						r++;
				end
			end
			REQ_RM_PORT: begin
				r = 0;
				while (r < heard_count) begin
					if (pi >= 0 && st_port[rank_slot[r]] == pi[3:0])
						drop_rank(r);
					else
						r++;
				end
			end
			REQ_CLEAR: begin
				for (int k = 0; k < CAPACITY; k++)
					st_used[k] = 1'b0;
				heard_count = 0;
			end
			REQ_FIRST, REQ_NEXT: begin
				if (req == REQ_FIRST)
					scan_pos = 0;
				for (r = scan_pos; r < heard_count && !took; r++) begin
					s = rank_slot[r];
					if (pi == -1 || (pi >= 0 && st_port[s] == pi[3:0])) begin
						scan_pos = r + 1;
						a = report_slot(s);
						took = 1'b1;
					end
				end
				if (!took)
					scan_pos = SCAN_DONE;
			end
			default: ;
		endcase
		return a;
	endfunction

	// Half the time no gap, else mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int p;
		p = $urandom_range(0, 99);
		if (p < 50)
			return 0;
		if (p < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Sends one request transaction and records its expected answer.
	task automatic send_req(logic [2:0] req, bit [79:0] call_in, logic signed [4:0] port,
			bit [31:0] heard = 0, bit bk = 0, bit [8:0] brg = 0, bit ds = 0,
			bit [15:0] new_dist = 0);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= req;
		s_axis_tdata  <= {new_dist, ds, brg, bk, heard, port, call_in[15:0], call_in[79:16]};
		do @(posedge clk); while (!s_axis_tready);
		answer_q.push_back(apply_request(req, call_in, port, heard, bk, brg, ds, new_dist));
	endtask

	// Lets every outstanding result drain, then some margin for the scan.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		wait (answer_q.size() == 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_max_entries(bit [4:0] v);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		max_setting = v;
	endtask

	bit [79:0] call_pool[6];

	// A pool call with random letter case, sometimes with junk past the end.
	function automatic bit [79:0] pool_call();
		bit [79:0] c;
		bit ended;
		c = call_pool[$urandom_range(0, 5)];
		ended = 1'b0;
		for (int i = 0; i < 10; i++) begin
			if (c[79-8*i -: 8] == 8'd0)
				ended = 1'b1;
			else if (!ended && c[79-8*i -: 8] >= "A" && c[79-8*i -: 8] <= "Z" && $urandom_range(0, 1))
				c[79-8*i -: 8] = c[79-8*i -: 8] | 8'h20;
			else if (ended && $urandom_range(0, 7) == 0)
				c[79-8*i -: 8] = 8'($urandom);
		end
		return c;
	endfunction

	task automatic test_directed();
		bit [79:0] nc, nl, junk;
		nc = {"N0CALL", 32'h0};
		nl = {"n0cAll", 32'h0};
		junk = {"N0CALL", 8'h00, 24'h414243};
		send_req(REQ_NEXT, nc, -5'sd1);
		send_req(REQ_TOUCH, nc, 5'sd0, 32'd100, 1, 9'd90, 1, 16'd1234);
		// Mixed-case call matches; bearing without a sane distance.
		send_req(REQ_TOUCH, nl, 5'sd0, 32'd200, 1, 9'd511, 0, 16'd7);
		send_req(REQ_TOUCH, junk, 5'sd1, 32'd300);
		send_req(REQ_TOUCH, nc, -5'sd2, 32'd400, 1, 9'd1, 1, 16'd1);
		send_req(REQ_TOUCH, '1, 5'sd15, '1, 1, 9'd359, 1, 16'hFFFF);
		send_req(REQ_TOUCH, {"AB1CDE-15X"}, 5'sd7, 32'h5A5A5A5A);
		send_req(REQ_FIRST, '0, -5'sd1);
		send_req(REQ_NEXT, '0, -5'sd1);
		send_req(REQ_NEXT, '0, -5'sd1);
		send_req(REQ_NEXT, '0, -5'sd1);
		send_req(REQ_NEXT, '0, -5'sd1);
		send_req(REQ_NEXT, '0, -5'sd1);
		send_req(REQ_FIRST, '0, 5'sd1);
		send_req(REQ_FIRST, '0, -5'sd3);
		send_req(REQ_SPARE_6, nc, 5'sd0);
		send_req(REQ_SPARE_7, nc, 5'sd0);
		send_req(REQ_RM_PORT, '0, -5'sd1);
		send_req(REQ_RM_CALL, nl, 5'sd3);
		send_req(REQ_RM_PORT, '0, 5'sd15);
		send_req(REQ_FIRST, '0, -5'sd1);
		send_req(REQ_CLEAR, '0, 5'sd0);
		send_req(REQ_FIRST, '0, -5'sd1);
	endtask

	task automatic test_max_entries();
		// With one entry allowed, each new station recycles the only slot.
		set_max_entries(5'd1);
		send_req(REQ_TOUCH, call_pool[0], 5'sd2, 32'd5, 1, 9'd10, 1, 16'd50);
		send_req(REQ_TOUCH, call_pool[0], 5'sd2, 32'd6);
		send_req(REQ_TOUCH, call_pool[1], 5'sd2, 32'd7);
		send_req(REQ_FIRST, '0, -5'sd1);
		set_max_entries(5'd0);
		send_req(REQ_TOUCH, call_pool[2], 5'sd3, 32'd8);
		send_req(REQ_FIRST, '0, -5'sd1);
		set_max_entries(5'd31);
		for (int i = 0; i < 18; i++)
			send_req(REQ_TOUCH, {8'h41 + i[7:0], 72'h0}, 5'(i % 16), i, 1, 9'(i), 1, 16'(i));
		send_req(REQ_FIRST, '0, -5'sd1);
		set_max_entries(5'd16);
	endtask

	task automatic test_random(int count);
		int p, op;
		logic signed [4:0] port;
		bit [79:0] c;
		for (int n = 0; n < count; n++) begin
			if (n % 300 == 150)
				drain();
			p = $urandom_range(0, 99);
			c = ($urandom_range(0, 19) == 0) ? {$urandom, $urandom, 16'($urandom)} : pool_call();
			port = ($urandom_range(0, 9) == 0) ? 5'($urandom) : 5'($urandom_range(0, 3));
			if (p < 50)
				op = REQ_TOUCH;
			else if (p < 62)
				op = REQ_FIRST;
			else if (p < 85)
				op = REQ_NEXT;
			else if (p < 91)
				op = REQ_RM_CALL;
			else if (p < 95)
				op = REQ_RM_PORT;
			else if (p < 97)
				op = REQ_CLEAR;
			else
				op = $urandom_range(6, 7);
			if ((op == REQ_FIRST || op == REQ_NEXT) && $urandom_range(0, 1))
				port = -5'sd1;
			send_req(op[2:0], c, port, $urandom, $urandom_range(0, 1), 9'($urandom),
				$urandom_range(0, 1), 16'($urandom));
		end
	endtask

	// Result side: random stalls, and each transaction checked in order.
	int ready_left = 0;
	bit ready_mode = 1'b0;
	station_res_t want;

	always @(posedge clk) begin
		if (ready_left == 0) begin
			int p;
			p = $urandom_range(0, 99);
			ready_mode = p < 55;
			ready_left = (p < 55) ? $urandom_range(1, 20) :
				(p < 92) ? $urandom_range(1, 3) : $urandom_range(20, 60);
		end
		ready_left--;
		m_axis_tready <= ready_mode;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (answer_q.size() == 0) begin
				$error("result transaction with no request waiting");
				fail_count++;
			end else begin
				want = answer_q.pop_front();
				if (m_axis_tuser !== want.found) begin
					$error("entry_found: expected %0d, got %0d", want.found, m_axis_tuser);
					fail_count++;
				end
				if (m_axis_tdata[63:0] !== want.head) begin
					$error("out_call_head: expected %h, got %h", want.head, m_axis_tdata[63:0]);
					fail_count++;
				end
				if (m_axis_tdata[79:64] !== want.tail) begin
					$error("out_call_tail: expected %h, got %h", want.tail, m_axis_tdata[79:64]);
					fail_count++;
				end
				if (m_axis_tdata[83:80] !== want.port) begin
					$error("out_port: expected %0d, got %0d", want.port, m_axis_tdata[83:80]);
					fail_count++;
				end
				if (m_axis_tdata[115:84] !== want.heard) begin
					$error("out_time: expected %h, got %h", want.heard, m_axis_tdata[115:84]);
					fail_count++;
				end
				if (m_axis_tdata[132:116] !== want.distance) begin
					$error("out_distance: expected %h, got %h", want.distance,
						m_axis_tdata[132:116]);
					fail_count++;
				end
				if (m_axis_tdata[141:133] !== want.brg) begin
					$error("out_bearing: expected %0d, got %0d", want.brg, m_axis_tdata[141:133]);
					fail_count++;
				end
			end
		end
	end

	// Watchdog: too long without any transaction on either side ends the run.
	int quiet_cycles = 0;

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		call_pool[0] = {"N0CALL", 32'h0};
		call_pool[1] = {"DL1ABC", 32'h0};
		call_pool[2] = {"PE9XYZ-1", 16'h0};
		call_pool[3] = {"W1AW", 48'h0};
		call_pool[4] = {"AB1CDE-15X"};
		call_pool[5] = {"KQ4Z-7", 32'h0};
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_wdata     = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = '0;
		m_axis_tready = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_max_entries();
		foreach (call_pool[i]) begin
			set_max_entries(i == 0 ? 5'd3 : (i == 1 ? 5'd16 : 5'($urandom_range(0, 31))));
			test_random(200);
		end
		drain();
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
`default_nettype wire
